// ----- sv/wh30_pkg.sv -----
// shared constants, tables and types for the wheel-30 to odd-only map expander
package wh30_pkg;

  localparam int BYTE_W = 8;
  // span register width
  localparam int SPAN_W = 32;
  // running value base 30*k stays below the span, plus one step of headroom
  localparam int BASE_W = SPAN_W + 1;
  // values per wheel byte
  localparam int WHEEL_STEP = 30;
  // result bytes one wheel byte can produce
  localparam int MAX_OUT = 3;
  localparam int CNT_W = 2;

  // residues coprime to 30, entry i belongs to wheel bit i
  localparam logic [7:0][4:0] RESIDUE = {
    5'd29, 5'd23, 5'd19, 5'd17, 5'd13, 5'd11, 5'd7, 5'd1
  };

  // odd-map bit masks for values 3 and 5 in byte 0
  localparam logic [BYTE_W-1:0] BIT_OF_3 = 8'h40;
  localparam logic [BYTE_W-1:0] BIT_OF_5 = 8'h20;

  // result bundle handed from the compute stage to the output stage
  typedef struct packed {
    logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]               count;
    logic                           last;
  } wh30_res_t;

endpackage

// ----- sv/wh30_if.sv -----
// valid/ready channel interfaces for wheel bytes and odd-map bytes

interface wh30_in_if;
  logic                          valid;
  logic                          ready;
  logic [wh30_pkg::BYTE_W-1:0]   wheel_byte;

  modport source (output valid, output wheel_byte, input ready);
  modport sink   (input valid, input wheel_byte, output ready);
endinterface

interface wh30_out_if;
  logic                          valid;
  logic                          ready;
  logic [wh30_pkg::BYTE_W-1:0]   odd_map_byte;
  logic                          last_of_run;
  logic                          end_of_map;

  modport source (output valid, output odd_map_byte, output last_of_run,
                  output end_of_map, input ready);
  modport sink   (input valid, input odd_map_byte, input last_of_run,
                  input end_of_map, output ready);
endinterface

// ----- sv/wh30_core.sv -----
// input register, span and stream state, and the per-byte bit scatter logic
module wh30_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [wh30_pkg::SPAN_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wh30_pkg::BYTE_W-1:0]   in_byte,
  output logic                          res_valid,
  input  logic                          res_ready,
  output wh30_pkg::wh30_res_t           res
);
  import wh30_pkg::*;

  logic                   in_v_r;
  logic [BYTE_W-1:0]      in_byte_r;
  logic [SPAN_W-1:0]      span_r;
  logic [BASE_W-1:0]      base_r;
  logic [BYTE_W-1:0]      carry_r;

  logic [BASE_W-1:0]      diff;
  logic [5:0]             dsat;
  logic                   active;
  logic                   last;
  logic [3:0]             sub;
  logic [3:0][BYTE_W-1:0] acc;
  logic [5:0]             pos;
  logic [5:0]             cnt_sum;
  logic [CNT_W-1:0]       count;
  logic                   advance;
  logic                   commit;

  // distance from the current block base to the end of the span
  always_comb begin
    diff   = {1'b0, span_r} - base_r;
    active = (span_r != '0) && (base_r < {1'b0, span_r});
    dsat   = (diff > BASE_W'(31)) ? 6'd32 : diff[5:0];
    last   = (dsat <= 6'd30);
    sub    = base_r[3:0];
  end

  // scatter the wheel bits into up to three odd-map bytes
  always_comb begin
    acc    = '0;
    acc[0] = carry_r;
    pos    = '0;
    if (base_r == '0) begin
      if (dsat > 6'd3) acc[0] = acc[0] | BIT_OF_3;
      if (dsat > 6'd5) acc[0] = acc[0] | BIT_OF_5;
    end
    for (int i = 0; i < 8; i++) begin
      pos = {2'b00, sub} + {1'b0, RESIDUE[i]};
      if (in_byte_r[i] && ({1'b0, RESIDUE[i]} < dsat)) begin
        acc[pos[5:4]] = acc[pos[5:4]] | (8'h80 >> pos[3:1]);
      end
    end
  end

  // number of bytes completed by this block
  always_comb begin
    if (last) begin
      cnt_sum = {2'b00, sub} + {1'b0, dsat[4:0]} + 6'd15;
    end else begin
      cnt_sum = {2'b00, sub} + 6'(WHEEL_STEP);
    end
    count = cnt_sum[5:4];
  end

  assign res.bytes = acc[MAX_OUT-1:0];
  assign res.count = count;
  assign res.last  = last;

  assign res_valid = in_v_r && active;
  // items past the end or with no map are dropped without a result
  assign advance   = in_v_r && (!active || res_ready);
  assign commit    = in_v_r && active && res_ready;
  assign in_ready  = !in_v_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  // span register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= '0;
    end else if (cfg_wr_en) begin
      span_r <= cfg_wr_data;
    end
  end

  // stream position and partial byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      carry_r <= '0;
    end else if (commit) begin
      base_r  <= base_r + BASE_W'(WHEEL_STEP);
      carry_r <= last ? '0 : acc[count];
    end
  end

endmodule

// ----- sv/wh30_emit.sv -----
// result register sending up to three odd-map bytes, one per ready cycle
module wh30_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_valid,
  output logic                          res_ready,
  input  wh30_pkg::wh30_res_t           res,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wh30_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last_run,
  output logic                          out_end_map
);
  import wh30_pkg::*;

  logic [MAX_OUT-1:0][BYTE_W-1:0] buf_r;
  logic [CNT_W-1:0]               rem_r;
  logic                           last_r;
  logic                           take;

  assign out_valid    = (rem_r != '0);
  assign out_byte     = buf_r[0];
  assign out_last_run = (rem_r == CNT_W'(1));
  assign out_end_map  = (rem_r == CNT_W'(1)) && last_r;
  assign take         = out_valid && out_ready;
  // reload while the final byte of the previous transaction goes out
  assign res_ready    = (rem_r == '0) || (out_last_run && out_ready);

  // remaining count and end flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      last_r <= 1'b0;
    end else if (res_ready && res_valid) begin
      rem_r  <= res.count;
      last_r <= res.last;
    end else if (take) begin
      rem_r  <= rem_r - CNT_W'(1);
    end
  end

  // byte buffer, shifts down as bytes leave
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      buf_r <= res.bytes;
    end else if (take) begin
      buf_r <= buf_r >> BYTE_W;
    end
  end

endmodule

// ----- sv/wheel30_to_odd_bitmap_expand.sv -----
// top level: wheel-30 prime bitmap to odd-only bitmap expander
//
//  port           dir    kind              carries
//  in_ch          sink   valid/ready       wheel_byte, one wheel-30 block
//  out_ch         source valid/ready       odd_map_byte, last_of_run, end_of_map
//  cfg_wr_en/data input  write strobe      span_values, 32 bits
//
// a wheel byte is registered, scattered combinationally into one to three map
// bytes, and parked in a result buffer that sends one byte per cycle while the
// output is ready, so the output port sets the pace. an item yields one or two
// bytes, 15 per 8 items, up to three on the last; items past the end drop.
// synchronous active-low reset clears the span, position and partial byte.
// a stalled output holds its byte; the next item loads as the last byte leaves.
module wheel30_to_odd_bitmap_expand (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [wh30_pkg::SPAN_W-1:0]   cfg_wr_data,
  wh30_in_if.sink                       in_ch,
  wh30_out_if.source                    out_ch
);
  import wh30_pkg::*;

  logic      res_valid;
  logic      res_ready;
  wh30_res_t res;

  // scatter stage
  wh30_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_byte     (in_ch.wheel_byte),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output stage
  wh30_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.odd_map_byte),
    .out_last_run (out_ch.last_of_run),
    .out_end_map  (out_ch.end_of_map)
  );

endmodule

// ----- bench/wh30_map_checker.sv -----
// checker for the wheel-30 to odd-only map expander: predicts and compares result bytes
`timescale 1ns / 100ps

module wh30_map_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [wh30_pkg::SPAN_W-1:0] cfg_wr_data,
  wh30_in_if                          in_ch,
  wh30_out_if                         out_ch,
  output int                          fail_count,
  output int                          bytes_due,
  output int                          bytes_seen,
  output logic [27:0]                 next_block
);
  import wh30_pkg::*;

  // block position is 28 bits wide, span is clamped so the block count fits
  localparam longint unsigned BLOCK_MAX = (64'd1 << 28) - 1;
  localparam longint unsigned SPAN_CAP  = BLOCK_MAX * WHEEL_STEP;
  localparam int              SHOW_MAX  = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] odd_map_byte;
    logic              last_of_run;
    logic              end_of_map;
  } map_byte_t;

  map_byte_t         due_q[$];
  logic [SPAN_W-1:0] span_reg;
  logic [27:0]       blk;
  logic [7:0]        partial;
  int                errs;
  int                seen;

  // scatter one wheel byte into the odd-only map bytes it completes
  function automatic void expand_wheel_byte(input logic [7:0] wb);
    longint unsigned span, n_wheel, n_odd, k, base_byte, stop, cnt, v, idx;
    logic [7:0]      acc [3];
    logic            last;
    map_byte_t       mb;
    int              i;
    span = 64'(span_reg);
    if (span > SPAN_CAP) span = SPAN_CAP;
    if (span == 0) return;
    n_wheel = (span + WHEEL_STEP - 1) / WHEEL_STEP;
    n_odd   = (span + 15) >> 4;
    k = 64'(blk);
    // past the end of the map: dropped
    if (k >= n_wheel) return;
    base_byte = (k * WHEEL_STEP) >> 4;
    acc[0] = partial;
    acc[1] = '0;
    acc[2] = '0;
    // 3 and 5 are not on the wheel but belong to the first map byte
    if (k == 0) begin
      if (span > 3) acc[0] |= BIT_OF_3;
      if (span > 5) acc[0] |= BIT_OF_5;
    end
    for (i = 0; i < 8; i++) begin
      v = k * WHEEL_STEP + RESIDUE[i];
      if (v < span && wb[i]) begin
        idx = (v >> 4) - base_byte;
        if (idx < 3) acc[idx] |= 8'h80 >> ((v >> 1) % 8);
      end
    end
    last = (k == n_wheel - 1);
    stop = last ? n_odd : (((k + 1) * WHEEL_STEP) >> 4);
    cnt  = (stop > base_byte) ? stop - base_byte : 0;
    if (cnt > MAX_OUT) cnt = 64'(MAX_OUT);
    for (i = 0; i < cnt; i++) begin
      mb.odd_map_byte = acc[i];
      mb.last_of_run  = (i + 1 == cnt);
      mb.end_of_map   = last && (i + 1 == cnt);
      due_q.push_back(mb);
    end
    partial = (!last && cnt < 3) ? acc[cnt] : '0;
    blk = 28'((k + 1) & BLOCK_MAX);
  endfunction

  always @(posedge clk) begin
    map_byte_t got, want;
    if (!rst_n) begin
      due_q.delete();
      span_reg = '0;
      blk      = '0;
      partial  = '0;
    end else begin
      // result side: compare against the oldest expected byte
      if (out_ch.valid && out_ch.ready) begin
        seen++;
        got.odd_map_byte = out_ch.odd_map_byte;
        got.last_of_run  = out_ch.last_of_run;
        got.end_of_map   = out_ch.end_of_map;
        if (due_q.size() == 0) begin
          errs++;
          if (errs <= SHOW_MAX)
            $display("%0t: unexpected byte: expected none, got %02h run %0b end %0b",
                     $time, got.odd_map_byte, got.last_of_run, got.end_of_map);
        end else begin
          want = due_q.pop_front();
          if (want !== got) begin
            errs++;
            if (errs <= SHOW_MAX)
              $display("%0t: mismatch: expected %02h run %0b end %0b, got %02h run %0b end %0b",
                       $time, want.odd_map_byte, want.last_of_run, want.end_of_map,
                       got.odd_map_byte, got.last_of_run, got.end_of_map);
          end
        end
      end
      // register write, then the wheel byte transaction
      if (cfg_wr_en) span_reg = cfg_wr_data;
      if (in_ch.valid && in_ch.ready) expand_wheel_byte(in_ch.wheel_byte);
    end
    fail_count <= errs;
    bytes_due  <= due_q.size();
    bytes_seen <= seen;
    next_block <= blk;
  end

endmodule

// ----- bench/tb_wheel30_to_odd_bitmap_expand.sv -----
// testbench top: stimulus, back-pressure, watchdog and verdict for the map expander
`timescale 1ns / 100ps

module tb_wheel30_to_odd_bitmap_expand;
  import wh30_pkg::*;

  localparam int ITEMS      = 480;
  localparam int SETTLE     = 8;
  localparam int IDLE_LIMIT = 4000;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [SPAN_W-1:0] cfg_wr_data;

  int          chk_fails;
  int          bytes_due;
  int          bytes_seen;
  logic [27:0] next_block;

  int sent_total;
  int span_writes;
  int idle_cycles;

  wh30_in_if  in_ch ();
  wh30_out_if out_ch ();

  wheel30_to_odd_bitmap_expand dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  wh30_map_checker map_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (chk_fails),
    .bytes_due   (bytes_due),
    .bytes_seen  (bytes_seen),
    .next_block  (next_block)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // one wheel byte transaction, returns at the accepting edge
  task automatic push_wheel(input logic [7:0] wb);
    in_ch.valid      <= 1'b1;
    in_ch.wheel_byte <= wb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_total++;
  endtask

  // hold the sender until every expected map byte has been taken
  task automatic drain_map;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
  endtask

  // drain, let dropped transactions settle, then write the span
  task automatic load_span(input logic [SPAN_W-1:0] span);
    drain_map();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= span;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    span_writes++;
  endtask

  // sender gap: mostly none or short, now and then long
  function automatic int sender_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // send a run of random wheel bytes with random gaps and the odd mid-run drain
  task automatic send_run(input int n, input bit burst);
    int i, gap;
    for (i = 0; i < n; i++) begin
      gap = sender_gap(burst);
      if (!burst && $urandom_range(0, 24) == 0) drain_map();
      else if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      push_wheel(8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: ready bursts separated by stalls, with long stall-free stretches
  initial begin
    int on_len, off_len;
    out_ch.ready <= 1'b0;
    forever begin
      on_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      off_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      out_ch.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      out_ch.ready <= 1'b0;
      repeat (off_len) @(posedge clk);
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    longint unsigned at, span;
    int kind, len, n, i;
    bit burst;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.wheel_byte <= '0;
    idle_cycles      <= 0;
    sent_total  = 0;
    span_writes = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // span is zero out of reset: no map, bytes dropped
    push_wheel(8'hFF);
    push_wheel(8'h00);
    // one-block map of five values: value one plus the bit for 3, then past the end
    load_span(32'd5);
    push_wheel(8'hFF);
    push_wheel(8'hAA);
    // span cleared again
    load_span('0);
    push_wheel(8'h55);
    // grow the map by a single value-less block
    load_span(32'd31);
    push_wheel(8'hFF);
    // full-range span, wheel byte extremes and each single bit
    load_span('1);
    push_wheel(8'h00);
    push_wheel(8'hFF);
    for (i = 0; i < 8; i++) push_wheel(8'h01 << i);
    push_wheel(8'h7E);
    push_wheel(8'h81);
    // span pulled back to the current block: further bytes dropped
    drain_map();
    load_span(next_block * WHEEL_STEP);
    push_wheel(8'hC3);

    // random phases of span settings and wheel byte runs
    drain_map();
    while (sent_total < ITEMS) begin
      at    = 64'(next_block);
      kind  = $urandom_range(0, 99);
      burst = ($urandom_range(0, 3) == 0);
      if (kind < 70) begin
        // map that ends a few blocks ahead, often run past its end
        len  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        span = (at + len - 1) * WHEEL_STEP + $urandom_range(1, WHEEL_STEP);
        load_span(span[SPAN_W-1:0]);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len + $urandom_range(0, 2);
      end else if (kind < 80) begin
        load_span(($urandom_range(0, 1) == 0) ? '1 : ($urandom() | 32'h8000_0000));
        n = $urandom_range(5, 40);
      end else if (kind < 87) begin
        load_span('0);
        n = $urandom_range(1, 3);
      end else if (kind < 93) begin
        // span at or behind the current block
        span = 64'($urandom_range(1, 32'(at * WHEEL_STEP)));
        load_span(span[SPAN_W-1:0]);
        n = $urandom_range(1, 3);
      end else begin
        n = $urandom_range(1, 10);
      end
      send_run(n, burst);
      drain_map();
    end

    drain_map();
    repeat (SETTLE + 4) @(posedge clk);
    $display("covered %0d wheel blocks from %0d wheel byte transactions under %0d span writes,",
             next_block, sent_total, span_writes);
    $display("with %0d odd-map bytes checked", bytes_seen);
    if (chk_fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
sv/wh30_pkg.sv
sv/wh30_if.sv
sv/wh30_core.sv
sv/wh30_emit.sv
sv/wheel30_to_odd_bitmap_expand.sv
bench/wh30_map_checker.sv
bench/tb_wheel30_to_odd_bitmap_expand.sv
